// ----- design/bpar_pkg.sv -----
// Shared types and constants for the button auto-repeat event queue.
package bpar_pkg;

  localparam int unsigned CfgW  = 8;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [CfgW-1:0] DelayReset  = 8'd12;
  localparam logic [CfgW-1:0] PeriodReset = 8'd5;

  typedef enum logic [0:0] {
    RegDelay  = 1'b0,
    RegPeriod = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] repeat_delay;
    logic [CfgW-1:0] repeat_period;
  } cfg_t;

  typedef struct packed {
    logic read_taken;
    logic q_empty;
    logic q_full;
  } bk_stat_t;

endpackage

// ----- design/bpar_front.sv -----
// Front end: per-button edge detection and repeat counters, forms one command per item.
module bpar_front #(
  parameter int unsigned BUTTONS = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 kind_i,
  input  logic [BUTTONS-1:0]   levels_i,
  input  bpar_pkg::cfg_t       cfg_i,
  output logic [2*BUTTONS:0]   cmd_o
);

  localparam int unsigned EvW = 2 * BUTTONS;

  logic [BUTTONS-1:0]        last_q, last_d;
  logic [bpar_pkg::CfgW-1:0] cnt_q   [BUTTONS];
  logic [bpar_pkg::CfgW-1:0] cnt_d   [BUTTONS];
  logic [bpar_pkg::CfgW-1:0] cnt_dec [BUTTONS];
  logic [EvW-1:0]            ev;

  // Event bit 2*i is a press of button i, bit 2*i+1 its repeat; low bits go first.
  always_comb begin
    last_d = last_q;
    ev     = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      cnt_d[i]   = cnt_q[i];
      cnt_dec[i] = cnt_q[i] - bpar_pkg::CfgW'(1);
      if (levels_i[i] != last_q[i]) begin
        last_d[i] = levels_i[i];
        if (!levels_i[i]) begin
          ev[2*i] = 1'b1;
        end else begin
          cnt_d[i] = cfg_i.repeat_delay;
        end
      end
      if (!levels_i[i]) begin
        if (cnt_dec[i] == '0) begin
          ev[2*i+1] = 1'b1;
          cnt_d[i]  = cfg_i.repeat_period;
        end else begin
          cnt_d[i]  = cnt_dec[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '1;
      for (int i = 0; i < BUTTONS; i++) begin
        cnt_q[i] <= bpar_pkg::DelayReset;
      end
    end else if (accept_i && !kind_i) begin
      last_q <= last_d;
      for (int i = 0; i < BUTTONS; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  assign cmd_o = {kind_i, (kind_i ? {EvW{1'b0}} : ev)};

endmodule

// ----- design/bpar_cmd_fifo.sv -----
// Two-entry command queue between the front end and the back end.
module bpar_cmd_fifo #(
  parameter int unsigned W = 5
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic         valid_o,
  output logic         full_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] ent_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ----- design/bpar_back.sv -----
// Back end: pushes queued events into the event FIFO and serves reads into the output register.
module bpar_back #(
  parameter int unsigned BUTTONS    = 2,
  parameter int unsigned FIFO_DEPTH = 16,
  localparam int unsigned BtnW      = (BUTTONS > 1) ? $clog2(BUTTONS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  logic [2*BUTTONS:0]   cmd_i,
  output logic                 cmd_pop_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 press_valid_o,
  output logic [BtnW-1:0]      press_button_o,
  output bpar_pkg::bk_stat_t   stat_o
);

  localparam int unsigned EvW  = 2 * BUTTONS;
  localparam int unsigned AW   = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  logic [BtnW-1:0] mem [FIFO_DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic [EvW-1:0]  done_q, done_d;
  logic            out_valid_q, press_valid_q;
  logic [BtnW-1:0] press_button_q;

  logic [EvW-1:0]  pending, pick, rest;
  logic [BtnW-1:0] sel_btn;
  logic            is_read, out_free, q_empty, q_full;
  logic            do_push, do_pop, read_take, tick_done;

  assign is_read  = cmd_i[EvW];
  assign pending  = cmd_i[EvW-1:0] & ~done_q;
  assign pick     = pending & (~pending + EvW'(1));
  assign rest     = pending & ~pick;
  assign out_free = !out_valid_q || out_ready_i;
  assign q_empty  = (count_q == '0);
  assign q_full   = (count_q == CntW'(FIFO_DEPTH));

  always_comb begin
    sel_btn = '0;
    for (int j = 0; j < EvW; j++) begin
      if (pick[j]) begin
        sel_btn = BtnW'(j >> 1);
      end
    end
  end

  // One event a beat; drop it when the FIFO is full.
  assign do_push   = cmd_valid_i && !is_read && (pick != '0) && !q_full;
  assign tick_done = cmd_valid_i && !is_read && (rest == '0);
  assign read_take = cmd_valid_i && is_read && out_free;
  assign do_pop    = read_take && !q_empty;
  assign cmd_pop_o = tick_done || read_take;

  always_comb begin
    done_d = done_q;
    if (cmd_valid_i && !is_read) begin
      done_d = tick_done ? '0 : (done_q | pick);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= sel_btn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (read_take) begin
      press_valid_q  <= !q_empty;
      press_button_q <= q_empty ? '0 : mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
        count_q  <= count_q + CntW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
        count_q  <= count_q - CntW'(1);
      end
      if (read_take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign press_valid_o  = press_valid_q;
  assign press_button_o = press_button_q;

  assign stat_o.read_taken = read_take;
  assign stat_o.q_empty    = q_empty;
  assign stat_o.q_full     = q_full;

endmodule

// ----- design/button_press_auto_repeat_queue_core.sv -----
// Button poller with auto-repeat and a press event FIFO: top level.
//
// Input channel (in_valid_i/in_ready_o): kind_i = 0 is a poll tick carrying one
// active-low level per button in levels_i; kind_i = 1 asks for the next queued event.
// Output channel (out_valid_o/out_ready_i): one beat per read, press_valid_o = 0 when
// the event FIFO was empty, else press_button_o names the pressed or repeating button.
// Ticks produce no output beat.
// Throughput: one item per cycle while the command queue has room. A tick that raises
// several events holds the back end until each is handled, since the event FIFO takes
// one write per cycle; the two-entry command queue absorbs that while the front keeps
// accepting. A read is registered in the command queue, then in the output register.
// A stalled receiver holds the output register; reads then back up in the command
// queue and in_ready_o drops once it is full. Ticks behind a stalled read wait too.
// Reset: all buttons released, counters at the reset delay of 12, FIFO empty,
// repeat_delay = 12, repeat_period = 5. No clearing pass is needed.
// Config (APB): repeat_delay at 0x0, repeat_period at 0x4; write only while idle.
module button_press_auto_repeat_queue_core #(
  parameter int unsigned BUTTONS    = 2,
  parameter int unsigned FIFO_DEPTH = 16,
  localparam int unsigned BtnW      = (BUTTONS > 1) ? $clog2(BUTTONS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [BUTTONS-1:0]            levels_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          press_valid_o,
  output logic [BtnW-1:0]               press_button_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpar_pkg::AddrW-1:0]    paddr,
  input  logic [bpar_pkg::DataW-1:0]    pwdata,
  output logic [bpar_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned CmdW = 2 * BUTTONS + 1;

  bpar_pkg::cfg_t       cfg_q;
  bpar_pkg::reg_idx_e   reg_idx;
  bpar_pkg::bk_stat_t   bk_stat;
  logic [CmdW-1:0]      cmd_in, cmd_head;
  logic                 accept, cmd_full, cmd_valid, cmd_pop, cfg_wr;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = bpar_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_delay  <= bpar_pkg::DelayReset;
      cfg_q.repeat_period <= bpar_pkg::PeriodReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        bpar_pkg::RegDelay:  cfg_q.repeat_delay  <= pwdata[bpar_pkg::CfgW-1:0];
        bpar_pkg::RegPeriod: cfg_q.repeat_period <= pwdata[bpar_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bpar_pkg::RegDelay:  prdata = bpar_pkg::DataW'(cfg_q.repeat_delay);
      bpar_pkg::RegPeriod: prdata = bpar_pkg::DataW'(cfg_q.repeat_period);
      default:             prdata = '0;
    endcase
  end

  assign in_ready_o = !cmd_full;
  assign accept     = in_valid_i && in_ready_o;

  bpar_front #(
    .BUTTONS (BUTTONS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .kind_i   (kind_i),
    .levels_i (levels_i),
    .cfg_i    (cfg_q),
    .cmd_o    (cmd_in)
  );

  bpar_cmd_fifo #(
    .W (CmdW)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .full_o  (cmd_full),
    .data_o  (cmd_head)
  );

  bpar_back #(
    .BUTTONS    (BUTTONS),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd_head),
    .cmd_pop_o      (cmd_pop),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .press_valid_o  (press_valid_o),
    .press_button_o (press_button_o),
    .stat_o         (bk_stat)
  );

  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.q_full |-> !bk_stat.q_empty)
    else $error("event FIFO reports full and empty");

  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bk_stat.read_taken && bk_stat.q_empty) |=> (out_valid_o && !press_valid_o))
    else $error("read of an empty FIFO returned a valid press");

  a_null_button: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !press_valid_o) |-> (press_button_o == '0))
    else $error("empty read carries a nonzero button");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the button auto-repeat press event queue.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          Buttons        = 2;
  localparam int          FifoDepth      = 16;
  localparam int          ClkHalfNs      = 6;
  localparam int          SettleCycles   = 12;
  localparam int          HoldOffCycles  = 120;
  localparam int          RunLimitCycles = 400_000;
  localparam int          MaxPrinted     = 100;
  localparam logic        KindTick       = 1'b0;
  localparam logic        KindRead       = 1'b1;
  localparam logic        Pressed        = 1'b0;
  localparam logic        Released       = 1'b1;
  localparam int          NumPhases      = 6;
  localparam int          FastRowStart   = 10;
  localparam int          NumRows        = 24;

  typedef struct packed {
    logic valid;
    logic button;
  } press_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] lv;
    logic       typed;
    press_t     want;
  } dir_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic                          kind_i;
  logic [Buttons-1:0]            levels_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic                          press_valid_o;
  logic                          press_button_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [bpar_pkg::AddrW-1:0]    paddr;
  logic [bpar_pkg::DataW-1:0]    pwdata;
  logic [bpar_pkg::DataW-1:0]    prdata;
  logic                          pready;

  button_press_auto_repeat_queue_core #(
    .BUTTONS   (Buttons),
    .FIFO_DEPTH(FifoDepth)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .levels_i      (levels_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .press_valid_o (press_valid_o),
    .press_button_o(press_button_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Predicted block state
  logic [bpar_pkg::CfgW-1:0] cur_delay;
  logic [bpar_pkg::CfgW-1:0] cur_period;
  logic                      held_lvl [Buttons];
  logic [bpar_pkg::CfgW-1:0] btn_cnt  [Buttons];
  logic                      event_fifo[$];
  press_t                    pending_presses[$];

  int  err_count;
  int  n_ticks;
  int  n_reads;
  int  n_beats;
  int  n_empty;
  int  n_drops;
  bit  hold_req;

  // Reset config: delay 12, period 5. Fast rows run with delay 1, period 1.
  dir_row_t dir_rows [NumRows] = '{
    '{KindRead, 2'b11, 1'b1, '{1'b0, 1'b0}},  // empty queue after reset
    '{KindTick, 2'b11, 1'b0, '{1'b0, 1'b0}},
    '{KindTick, 2'b10, 1'b0, '{1'b0, 1'b0}},  // press button 0
    '{KindRead, 2'b00, 1'b1, '{1'b1, 1'b0}},
    '{KindRead, 2'b11, 1'b1, '{1'b0, 1'b0}},
    '{KindTick, 2'b01, 1'b0, '{1'b0, 1'b0}},  // release 0, press 1
    '{KindRead, 2'b10, 1'b1, '{1'b1, 1'b1}},
    '{KindTick, 2'b11, 1'b0, '{1'b0, 1'b0}},
    '{KindTick, 2'b00, 1'b0, '{1'b0, 1'b0}},  // both pressed on one tick
    '{KindRead, 2'b01, 1'b1, '{1'b1, 1'b0}},
    '{KindTick, 2'b11, 1'b0, '{1'b0, 1'b0}},  // release loads counters with 1
    '{KindTick, 2'b00, 1'b0, '{1'b0, 1'b0}},  // press and repeat on one tick
    '{KindRead, 2'b11, 1'b1, '{1'b1, 1'b1}},  // leftover from both-pressed tick
    '{KindRead, 2'b00, 1'b1, '{1'b1, 1'b0}},
    '{KindTick, 2'b00, 1'b0, '{1'b0, 1'b0}},
    '{KindTick, 2'b00, 1'b0, '{1'b0, 1'b0}},
    '{KindTick, 2'b00, 1'b0, '{1'b0, 1'b0}},
    '{KindTick, 2'b00, 1'b0, '{1'b0, 1'b0}},
    '{KindTick, 2'b00, 1'b0, '{1'b0, 1'b0}},
    '{KindTick, 2'b00, 1'b0, '{1'b0, 1'b0}},
    '{KindTick, 2'b00, 1'b0, '{1'b0, 1'b0}},
    '{KindTick, 2'b00, 1'b0, '{1'b0, 1'b0}},  // queue full: repeats dropped
    '{KindRead, 2'b10, 1'b0, '{1'b0, 1'b0}},
    '{KindRead, 2'b01, 1'b0, '{1'b0, 1'b0}}
  };

  int ph_delay  [NumPhases] = '{1, 255, 1, 255, 0, 0};
  int ph_period [NumPhases] = '{1, 255, 255, 1, 0, 0};
  int ph_items  [NumPhases] = '{240, 120, 160, 120, 180, 180};

  initial begin : clk_gen
    clk_i = 1'b0;
    forever #(ClkHalfNs) clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MaxPrinted) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic void model_reset();
    cur_delay  = bpar_pkg::DelayReset;
    cur_period = bpar_pkg::PeriodReset;
    for (int b = 0; b < Buttons; b++) begin
      held_lvl[b] = Released;
      btn_cnt[b]  = bpar_pkg::DelayReset;
    end
    event_fifo.delete();
  endfunction

  function automatic void queue_event(input logic b);
    if (event_fifo.size() < FifoDepth) event_fifo.push_back(b);
    else n_drops++;
  endfunction

  // Apply one tick or read to the predicted state; return 1 when a beat follows.
  function automatic bit poll_or_pop(input logic k, input logic [1:0] lv, output press_t res);
    logic now;
    res = '0;
    if (k == KindTick) begin
      n_ticks++;
      for (int b = 0; b < Buttons; b++) begin
        now = lv[b];
        if (now != held_lvl[b]) begin
          held_lvl[b] = now;
          if (now == Pressed) queue_event(1'(b));
          else btn_cnt[b] = cur_delay;
        end
        if (held_lvl[b] == Pressed) begin
          btn_cnt[b] = btn_cnt[b] - 1'b1;
          if (btn_cnt[b] == '0) begin
            queue_event(1'(b));
            btn_cnt[b] = cur_period;
          end
        end
      end
      return 1'b0;
    end
    n_reads++;
    if (event_fifo.size() != 0) begin
      res.valid  = 1'b1;
      res.button = event_fifo.pop_front();
    end else begin
      n_empty++;
    end
    return 1'b1;
  endfunction

  // Offer one beat and hold it until accepted.
  task automatic send_item(input logic k, input logic [1:0] lv, input logic typed = 1'b0,
                           input press_t want = '0);
    press_t res;
    in_valid_i <= 1'b1;
    kind_i     <= k;
    levels_i   <= lv;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (poll_or_pop(k, lv, res)) pending_presses.push_back(typed ? want : res);
  endtask

  task automatic idle_wait();
    while (pending_presses.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic check_reg(input bpar_pkg::reg_idx_e idx,
                           input logic [bpar_pkg::CfgW-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= bpar_pkg::AddrW'(4 * int'(idx));
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[bpar_pkg::CfgW-1:0] !== val)
      report_mismatch($sformatf("register %s reads %0d, expected %0d",
                                idx.name(), prdata[bpar_pkg::CfgW-1:0], val));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input bpar_pkg::reg_idx_e idx,
                           input logic [bpar_pkg::CfgW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bpar_pkg::AddrW'(4 * int'(idx));
    pwdata  <= bpar_pkg::DataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      bpar_pkg::RegDelay:  cur_delay  = val;
      bpar_pkg::RegPeriod: cur_period = val;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    check_reg(idx, val);
  endtask

  // Bursts of random length, random gaps, per-burst read mix, sticky levels.
  task automatic run_phase(input int n_items, input int sticky_pct);
    int         burst_left;
    int         gap;
    int         read_pct;
    logic [1:0] held;
    logic [1:0] lv;
    logic       k;
    burst_left = 0;
    read_pct   = 30;
    held       = 2'b11;
    for (int sent = 0; sent < n_items; sent++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 24);
        read_pct   = $urandom_range(5, 75);
      end
      burst_left--;
      k = ($urandom_range(0, 99) < read_pct) ? KindRead : KindTick;
      if ($urandom_range(0, 99) >= sticky_pct) held = 2'($urandom_range(0, 3));
      // one-tick glitch now and then, without moving the held pattern
      lv = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3)) : held;
      if (k == KindRead) lv = 2'($urandom_range(0, 3));
      send_item(k, lv);
    end
    in_valid_i <= 1'b0;
    idle_wait();
  endtask

  initial begin : rx_pattern
    int   span;
    int   mode;
    int   hold_left;
    span        = 0;
    mode        = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 2);
          span = $urandom_range(4, 40);
        end
        span--;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    press_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_beats++;
      if (pending_presses.size() == 0) begin
        report_mismatch($sformatf("beat with nothing expected: valid=%0b button=%0d",
                                  press_valid_o, press_button_o));
      end else begin
        want = pending_presses.pop_front();
        if (press_valid_o !== want.valid)
          report_mismatch($sformatf("press_valid %0b, expected %0b",
                                    press_valid_o, want.valid));
        if (press_button_o !== want.button)
          report_mismatch($sformatf("press_button %0d, expected %0d",
                                    press_button_o, want.button));
      end
    end
  end

  initial begin : main_seq
    logic [bpar_pkg::CfgW-1:0] d;
    logic [bpar_pkg::CfgW-1:0] per;
    in_valid_i = 1'b0;
    kind_i     = KindTick;
    levels_i   = '1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rst_ni     = 1'b0;
    hold_req   = 1'b0;
    err_count  = 0;
    n_ticks    = 0;
    n_reads    = 0;
    n_beats    = 0;
    n_empty    = 0;
    n_drops    = 0;
    model_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_reg(bpar_pkg::RegDelay, bpar_pkg::DelayReset);
    check_reg(bpar_pkg::RegPeriod, bpar_pkg::PeriodReset);

    for (int i = 0; i < NumRows; i++) begin
      if (i == FastRowStart) begin
        in_valid_i <= 1'b0;
        idle_wait();
        cfg_write(bpar_pkg::RegDelay, 8'd1);
        cfg_write(bpar_pkg::RegPeriod, 8'd1);
      end
      send_item(dir_rows[i].kind, dir_rows[i].lv, dir_rows[i].typed, dir_rows[i].want);
    end
    in_valid_i <= 1'b0;
    idle_wait();

    for (int p = 0; p < NumPhases; p++) begin
      d   = (ph_delay[p] == 0)  ? bpar_pkg::CfgW'($urandom_range(1, 12))
                                : bpar_pkg::CfgW'(ph_delay[p]);
      per = (ph_period[p] == 0) ? bpar_pkg::CfgW'($urandom_range(1, 12))
                                : bpar_pkg::CfgW'(ph_period[p]);
      cfg_write(bpar_pkg::RegDelay, d);
      cfg_write(bpar_pkg::RegPeriod, per);
      // stall the receiver long enough to back up reads and drop in_ready_o
      if (p == 0) hold_req = 1'b1;
      run_phase(ph_items[p], (d > 8'd100) ? 99 : 85);
    end

    $display("Covered %0d items (%0d poll ticks, %0d reads) over %0d register settings.",
             n_ticks + n_reads, n_ticks, n_reads, NumPhases + 2);
    $display("Checked %0d beats: %0d empty-queue reads, %0d events dropped at a full queue.",
             n_beats, n_empty, n_drops);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(RunLimitCycles * 2 * ClkHalfNs);
    $display("Timeout with %0d beats still expected", pending_presses.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
